>>> design/gcl_pkg.sv
// gcl_pkg: shared types and constants for the gcd / lcm unit
// no dependencies
`default_nettype none

package gcl_pkg;

  localparam int OPERAND_WIDTH_DEF = 32;
  localparam int DIVISOR_W         = 32;
  localparam int MULTIPLE_W        = 64;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GCD,
    S_DIV,
    S_MUL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic gcd_step;
    logic div_start;
    logic div_step;
    logic mul;
  } cmd_t;

  typedef struct packed {
    logic in_zero;
    logic gcd_done;
    logic div_last;
  } sts_t;

endpackage

`default_nettype wire

>>> design/gcl_ctrl.sv
// gcl_ctrl: sequencer for the gcd / lcm unit
// depends on gcl_pkg; drives gcl_dp by command word, reads its status
`default_nettype none

module gcl_ctrl
  import gcl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  output logic      out_valid,
  output cmd_t      cmd,
  input  wire sts_t sts
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = sts.in_zero ? S_DONE : S_GCD;
        end
      end
      S_GCD: begin
        if (sts.gcd_done) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_last) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL:   state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_GCD: begin
        cmd.gcd_step  = !sts.gcd_done;
        cmd.div_start = sts.gcd_done;
      end
      S_DIV:   cmd.div_step = 1'b1;
      S_MUL:   cmd.mul = 1'b1;
      S_DONE:  out_valid = 1'b1;
      default: busy = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

>>> design/gcl_dp.sv
// gcl_dp: datapath with binary gcd, restoring divider and multiplier
// depends on gcl_pkg; commanded by gcl_ctrl
`default_nettype none

module gcl_dp
  import gcl_pkg::*;
#(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire cmd_t                  cmd,
  output sts_t                       sts,
  input  wire logic [DIVISOR_W-1:0]  in_first_operand,
  input  wire logic [DIVISOR_W-1:0]  in_second_operand,
  output logic      [DIVISOR_W-1:0]  out_divisor,
  output logic      [MULTIPLE_W-1:0] out_multiple
);

  localparam int W  = OPERAND_WIDTH;
  localparam int KW = $clog2(W);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]   a_in;
  logic [W-1:0]   b_in;

  logic [W-1:0]   a_r, a_nxt;
  logic [W-1:0]   b_r, b_nxt;
  logic [W-1:0]   u_r, u_nxt;
  logic [W-1:0]   v_r, v_nxt;
  logic [KW-1:0]  k_r, k_nxt;
  logic [W-1:0]   g_r, g_nxt;
  logic [W-1:0]   quot_r, quot_nxt;
  logic [W-1:0]   rem_r, rem_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [2*W-1:0] prod_r, prod_nxt;

  logic [W:0]     rem_sh;
  logic [W:0]     rem_diff;

  assign a_in = in_first_operand[W-1:0];
  assign b_in = in_second_operand[W-1:0];

  assign rem_sh   = {rem_r, quot_r[W-1]};
  assign rem_diff = rem_sh - {1'b0, g_r};

  assign sts.in_zero  = (a_in == '0) || (b_in == '0);
  assign sts.gcd_done = (u_r == v_r);
  assign sts.div_last = (cnt_r == CW'(W - 1));

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    u_nxt    = u_r;
    v_nxt    = v_r;
    k_nxt    = k_r;
    g_nxt    = g_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    prod_nxt = prod_r;
    if (cmd.load) begin
      a_nxt    = a_in;
      b_nxt    = b_in;
      u_nxt    = a_in;
      v_nxt    = b_in;
      k_nxt    = '0;
      g_nxt    = W'(1);
      prod_nxt = '0;
    end
    if (cmd.gcd_step) begin
      if (!u_r[0] && !v_r[0]) begin
        u_nxt = u_r >> 1;
        v_nxt = v_r >> 1;
        k_nxt = k_r + KW'(1);
      end else if (!u_r[0]) begin
        u_nxt = u_r >> 1;
      end else if (!v_r[0]) begin
        v_nxt = v_r >> 1;
      end else if (u_r > v_r) begin
        u_nxt = u_r - v_r;
      end else begin
        v_nxt = v_r - u_r;
      end
    end
    if (cmd.div_start) begin
      g_nxt    = u_r << k_r;
      quot_nxt = a_r;
      rem_nxt  = '0;
      cnt_nxt  = '0;
    end
    if (cmd.div_step) begin
      cnt_nxt = cnt_r + CW'(1);
      if (!rem_diff[W]) begin
        rem_nxt  = rem_diff[W-1:0];
        quot_nxt = {quot_r[W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[W-1:0];
        quot_nxt = {quot_r[W-2:0], 1'b0};
      end
    end
    if (cmd.mul) begin
      prod_nxt = (2*W)'(quot_r) * (2*W)'(b_r);
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    u_r    <= u_nxt;
    v_r    <= v_nxt;
    k_r    <= k_nxt;
    g_r    <= g_nxt;
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    prod_r <= prod_nxt;
  end

  assign out_divisor  = DIVISOR_W'(g_r);
  assign out_multiple = MULTIPLE_W'(prod_r);

endmodule

`default_nettype wire

>>> design/gcd_lcm_unit.sv
// gcd_lcm_unit: greatest common divisor and least common multiple
// depends on gcl_pkg, gcl_ctrl and gcl_dp
//
// usage: drive in_first_operand and in_second_operand and raise start while
// busy is low; the word is taken at that clock edge and busy rises on the
// next cycle. operand bits at or above OPERAND_WIDTH are ignored.
// when the work is done, out_valid is high for exactly one cycle with
// out_divisor and out_multiple; the receiver must take the word then, it
// cannot stall the block. busy falls in the cycle after out_valid, so a new
// word can be taken in the cycle right after out_valid.
// if either operand is zero the result is divisor 1, multiple 0, with
// out_valid in the cycle after the accepting edge. otherwise the binary
// gcd loop runs its halving and subtraction steps (none for equal
// operands), then the gcd is formed, the restoring divider forms
// first/gcd and the multiplier forms the multiple. one word in flight.
// reset (rst_n low, synchronous) returns the sequencer to idle; a word in
// progress is dropped and no result is produced for it.
`default_nettype none

module gcd_lcm_unit
  import gcl_pkg::*;
#(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [DIVISOR_W-1:0]  in_first_operand,
  input  wire logic [DIVISOR_W-1:0]  in_second_operand,
  output logic                       out_valid,
  output logic      [DIVISOR_W-1:0]  out_divisor,
  output logic      [MULTIPLE_W-1:0] out_multiple
);

  cmd_t cmd;
  sts_t sts;

  gcl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  gcl_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk               (clk),
    .cmd               (cmd),
    .sts               (sts),
    .in_first_operand  (in_first_operand),
    .in_second_operand (in_second_operand),
    .out_divisor       (out_divisor),
    .out_multiple      (out_multiple)
  );

endmodule

`default_nettype wire

>>> bench/gcd_lcm_unit_tb.sv
// gcd_lcm_unit_tb: self-checking bench for the gcd / lcm unit, directed and random operands
// depends on gcl_pkg and gcd_lcm_unit; a local gcd / lcm predictor checks every result word

module gcd_lcm_unit_tb;
  import gcl_pkg::*;

  localparam int OP_W = OPERAND_WIDTH_DEF;
  localparam logic [DIVISOR_W-1:0] ALL_ONES = '1;
  localparam logic [DIVISOR_W-1:0] TOP_BIT = {1'b1, {(DIVISOR_W-1){1'b0}}};

  typedef struct {
    logic [DIVISOR_W-1:0]  a;
    logic [DIVISOR_W-1:0]  b;
    logic [DIVISOR_W-1:0]  divisor;
    logic [MULTIPLE_W-1:0] multiple;
  } lcm_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [DIVISOR_W-1:0]  in_first_operand;
  logic [DIVISOR_W-1:0]  in_second_operand;
  logic                  out_valid;
  logic [DIVISOR_W-1:0]  out_divisor;
  logic [MULTIPLE_W-1:0] out_multiple;

  lcm_result_t pending_results[$];
  int          errors;
  int          words_sent;
  int          words_checked;
  int          zero_words;
  int          wide_words;
  bit          no_gaps;

  gcd_lcm_unit #(
    .OPERAND_WIDTH(OP_W)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_first_operand (in_first_operand),
    .in_second_operand(in_second_operand),
    .out_valid        (out_valid),
    .out_divisor      (out_divisor),
    .out_multiple     (out_multiple)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("** gcd_lcm_unit: FAILED **");
    $finish;
  end

  function automatic lcm_result_t predict_gcd_lcm(input logic [DIVISOR_W-1:0] a,
                                                  input logic [DIVISOR_W-1:0] b);
    lcm_result_t     r;
    logic [63:0]     mask;
    logic [63:0]     x;
    logic [63:0]     y;
    logic [63:0]     rem;
    mask = (64'd1 << OP_W) - 64'd1;
    r.a = a;
    r.b = b;
    x = a & mask;
    y = b & mask;
    if (x == 0 || y == 0) begin
      r.divisor  = 1;
      r.multiple = 0;
    end else begin
      while (y != 0) begin
        rem = x % y;
        x   = y;
        y   = rem;
      end
      r.divisor  = x[DIVISOR_W-1:0];
      r.multiple = ((a & mask) / x) * (b & mask);
    end
    return r;
  endfunction

  // predict on every accepted word, compare every result word
  always @(posedge clk) begin : result_check
    lcm_result_t want;
    if (rst_n && start && !busy) begin
      pending_results.push_back(predict_gcd_lcm(in_first_operand, in_second_operand));
    end
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word divisor %0d multiple %0d",
                 $time, out_divisor, out_multiple);
      end else begin
        want = pending_results.pop_front();
        words_checked++;
        if (want.multiple == 0) zero_words++;
        if (want.multiple[MULTIPLE_W-1:DIVISOR_W] != 0) wide_words++;
        if (out_divisor !== want.divisor) begin
          errors++;
          $display("%0t: divisor mismatch for %0d, %0d: expected %0d actual %0d",
                   $time, want.a, want.b, want.divisor, out_divisor);
        end
        if (out_multiple !== want.multiple) begin
          errors++;
          $display("%0t: multiple mismatch for %0d, %0d: expected %0d actual %0d",
                   $time, want.a, want.b, want.multiple, out_multiple);
        end
      end
    end
  end

  task automatic issue_operands(input logic [DIVISOR_W-1:0] a, input logic [DIVISOR_W-1:0] b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start             <= 1'b1;
    in_first_operand  <= a;
    in_second_operand <= b;
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  task automatic test_zero_operands();
    issue_operands('0, '0);
    issue_operands('0, ALL_ONES);
    issue_operands(ALL_ONES, '0);
    issue_operands('0, 1);
    issue_operands(5, '0);
  endtask

  task automatic test_extreme_values();
    issue_operands(1, 1);
    issue_operands(ALL_ONES, ALL_ONES);
    issue_operands(ALL_ONES, 1);
    issue_operands(1, ALL_ONES);
    issue_operands(ALL_ONES, ALL_ONES - 1);
    issue_operands(TOP_BIT, TOP_BIT);
    issue_operands(TOP_BIT, 1);
    issue_operands(ALL_ONES, TOP_BIT);
    issue_operands(32'd4294967291, 32'd4294967279);
    issue_operands(32'hAAAA_AAAA, 32'h5555_5555);
  endtask

  task automatic test_shared_factors();
    issue_operands(12, 18);
    issue_operands(32'h8000_0000, 32'h0030_0000);
    issue_operands(32'h1234_5678, 32'h1234_5678);
    issue_operands(7 * 65521, 11 * 65521);
    issue_operands(32'hFFFF_FFFE, 32'hFFFF_FFFC);
    issue_operands(3, 32'hC000_0000);
  endtask

  task automatic test_random_mix(input int count);
    logic [DIVISOR_W-1:0] a;
    logic [DIVISOR_W-1:0] b;
    logic [DIVISOR_W-1:0] g;
    int                   gw;
    int                   kind;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
      kind = $urandom_range(0, 9);
      a = $urandom;
      b = $urandom;
      case (kind)
        0: begin
          if ($urandom_range(0, 2) != 0) a = '0;
          else b = '0;
          if ($urandom_range(0, 3) == 0) b = '0;
        end
        3, 4, 5: begin
          gw = $urandom_range(1, 31);
          g = ($urandom >> (DIVISOR_W - gw)) | 1'b1;
          g = g << $urandom_range(0, DIVISOR_W - gw);
          a = g * ($urandom >> gw);
          b = g * ($urandom >> gw);
          if (a == 0) a = g;
          if (b == 0) b = g;
        end
        6: begin
          a = a << $urandom_range(0, 31);
          b = b << $urandom_range(0, 31);
        end
        7: begin
          a = $urandom_range(1, 255);
          b = $urandom_range(1, 255);
        end
        8: begin
          if ($urandom_range(0, 1) == 0) b = a;
          else b = a * $urandom_range(2, 7);
        end
        9: begin
          if ($urandom_range(0, 1) == 0) a = ALL_ONES;
          else a = 1;
        end
        default: ;
      endcase
      if ($urandom_range(0, 1) == 0) begin
        g = a;
        a = b;
        b = g;
      end
      issue_operands(a, b);
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    start             = 1'b0;
    in_first_operand  = '0;
    in_second_operand = '0;
    errors            = 0;
    words_sent        = 0;
    words_checked     = 0;
    zero_words        = 0;
    wide_words        = 0;
    no_gaps           = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_zero_operands();
    test_extreme_values();
    test_shared_factors();
    test_random_mix(1300);

    start <= 1'b0;
    while (words_checked < words_sent) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("operand pairs sent %0d, result words checked %0d, mismatches %0d",
             words_sent, words_checked, errors);
    $display("zero-operand results %0d, multiples wider than 32 bits %0d",
             zero_words, wide_words);
    if (errors == 0) begin
      $display("** gcd_lcm_unit: PASSED **");
    end else begin
      $display("** gcd_lcm_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> gcd_lcm_unit.f
design/gcl_pkg.sv
design/gcl_ctrl.sv
design/gcl_dp.sv
design/gcd_lcm_unit.sv
bench/gcd_lcm_unit_tb.sv
